/* design/vda_pkg.sv */
package vda_pkg;

  // Width of the lane count field carried with every request
  localparam int LANES_VALID_W = 3;

  // Result queue between the finishing stage and the output port
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  // Metric selection codes; the fourth code behaves like squared L2
  typedef enum logic [1:0] {
    METRIC_L2           = 2'd0,
    METRIC_ONE_MINUS_IP = 2'd1,
    METRIC_TWO_MINUS_IP = 2'd2
  } metric_t;

  // Control that travels alongside the lane stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

/* design/vector_distance_accumulator_top.sv */
// Vector distance accumulator. Each request carries LANES element pairs of two
// signed Q1.15 vectors (s_tdata, lowest lanes first) and a lane count; s_tlast
// marks the final group of a vector pair. Groups are summed as squared
// differences (metric 0 or 3) or products (metric 1 and 2) into a 48-bit
// saturating Q.30 sum; on the last group one result leaves on the m_ side:
// the sum, 1.0 minus it, or 2.0 minus it, with m_tuser flagging saturation.
// One request is taken every cycle while s_tready is high; a result passes
// through the lane products, group adder and accumulator, then an eight-entry
// result queue. s_tready drops only when that queue plus the results still
// in the pipeline could fill it. Change cfg_data only while no vector pair is
// in progress.
module vector_distance_accumulator_top #(
  parameter int LANES         = 4,
  parameter int ELEMENT_WIDTH = 16,
  parameter int SUM_WIDTH     = 48
) (
  input  logic clk,
  input  logic rst,
  // metric_mode
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  // a lanes 0..LANES-1, b lanes 0..LANES-1, lanes_valid, zero fill
  input  logic [((2*LANES*ELEMENT_WIDTH+vda_pkg::LANES_VALID_W+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tlast,   // last_group
  // distance_value, zero fill
  output logic [((SUM_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  output logic m_tuser    // saturated
);
  import vda_pkg::*;

  localparam int EW   = ELEMENT_WIDTH;
  localparam int PW   = 2 * EW + 2;
  localparam int OW   = ((SUM_WIDTH+7)/8)*8;
  localparam int NV_LO = 2 * LANES * EW;

  // Metric register
  metric_t mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= METRIC_L2;
    end else if (cfg_valid) begin
      unique case (cfg_data)
        METRIC_ONE_MINUS_IP: mode <= METRIC_ONE_MINUS_IP;
        METRIC_TWO_MINUS_IP: mode <= METRIC_TWO_MINUS_IP;
        default:             mode <= METRIC_L2;
      endcase
    end
  end

  logic inner;
  assign inner = (mode == METRIC_ONE_MINUS_IP) || (mode == METRIC_TWO_MINUS_IP);

  // Request accept and lane stage
  logic                       accept;
  logic [LANES_VALID_W-1:0]   lanes_valid;
  logic [LANES-1:0][PW-1:0]   prods;
  stage_ctrl_t                ctrl1;

  assign accept      = s_tvalid & s_tready;
  assign lanes_valid = s_tdata[NV_LO +: LANES_VALID_W];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic active;
    assign active = accept && (32'(lanes_valid) > i);
    vda_lane #(
      .ELEMENT_WIDTH (EW),
      .PROD_WIDTH    (PW)
    ) u_lane (
      .clk    (clk),
      .a      (s_tdata[i*EW +: EW]),
      .b      (s_tdata[(LANES+i)*EW +: EW]),
      .active (active),
      .inner  (inner),
      .prod   (prods[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
    end else begin
      ctrl1.valid <= accept;
      ctrl1.last  <= accept & s_tlast;
    end
  end

  // Accumulate and finish
  logic                 res_valid;
  logic [SUM_WIDTH-1:0] res_dist;
  logic                 res_sat;
  logic [1:0]           pending;

  vda_accum #(
    .LANES         (LANES),
    .ELEMENT_WIDTH (EW),
    .SUM_WIDTH     (SUM_WIDTH),
    .PROD_WIDTH    (PW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .ctrl      (ctrl1),
    .prods     (prods),
    .res_valid (res_valid),
    .res_dist  (res_dist),
    .res_sat   (res_sat),
    .pending   (pending)
  );

  // Result queue
  logic [SUM_WIDTH:0]   queue [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W-1:0] inflight;
  logic                 pop;

  assign pop      = m_tvalid & m_tready;
  assign inflight = OUT_CNT_W'(pending) + OUT_CNT_W'(ctrl1.last);
  assign s_tready = (count + inflight) < OUT_CNT_W'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (res_valid) begin
      queue[wr_ptr] <= {res_sat, res_dist};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(res_valid) - OUT_CNT_W'(pop);
    end
  end

  assign m_tvalid = count != '0;
  assign m_tdata  = OW'(queue[rd_ptr][SUM_WIDTH-1:0]);
  assign m_tuser  = queue[rd_ptr][SUM_WIDTH];

endmodule

/* design/vda_lane.sv */
module vda_lane #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int PROD_WIDTH    = 34
) (
  input  logic                         clk,
  input  logic signed [ELEMENT_WIDTH-1:0] a,
  input  logic signed [ELEMENT_WIDTH-1:0] b,
  input  logic                         active,
  input  logic                         inner,
  output logic signed [PROD_WIDTH-1:0] prod
);
  localparam int EW = ELEMENT_WIDTH;

  logic signed [EW:0]       diff;
  logic signed [2*EW+1:0]   sq;
  logic signed [2*EW-1:0]   mul;
  logic signed [PROD_WIDTH-1:0] prod_next;

  // One squared difference or one product per lane
  assign diff = {a[EW-1], a} - {b[EW-1], b};
  assign sq   = diff * diff;
  assign mul  = a * b;

  always_comb begin
    if (!active) begin
      prod_next = '0;
    end else if (inner) begin
      prod_next = {{2{mul[2*EW-1]}}, mul};
    end else begin
      prod_next = sq;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

/* design/vda_accum.sv */
module vda_accum #(
  parameter int LANES         = 4,
  parameter int ELEMENT_WIDTH = 16,
  parameter int SUM_WIDTH     = 48,
  parameter int PROD_WIDTH    = 34
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  vda_pkg::metric_t                       mode,
  input  vda_pkg::stage_ctrl_t                   ctrl,
  input  logic [LANES-1:0][PROD_WIDTH-1:0]       prods,
  output logic                                   res_valid,
  output logic [SUM_WIDTH-1:0]                   res_dist,
  output logic                                   res_sat,
  output logic [1:0]                             pending
);
  import vda_pkg::*;

  localparam int GW   = PROD_WIDTH + $clog2(LANES) + 1;
  localparam int AW   = ((SUM_WIDTH > GW) ? SUM_WIDTH : GW) + 1;
  localparam int FRAC = 2 * (ELEMENT_WIDTH - 1);
  localparam int FW   = ((SUM_WIDTH > FRAC + 2) ? SUM_WIDTH : FRAC + 2) + 2;

  localparam logic signed [AW-1:0] A_MAX =
    {{(AW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] A_MIN = ~A_MAX;
  localparam logic signed [FW-1:0] F_MAX =
    {{(FW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [FW-1:0] F_MIN = ~F_MAX;
  localparam logic signed [FW-1:0] F_ONE = FW'(1) << FRAC;

  // Group sum stage
  logic signed [GW-1:0] group_next;
  logic signed [GW-1:0] group;
  logic                 v2;
  logic                 last2;

  always_comb begin
    group_next = '0;
    for (int i = 0; i < LANES; i++) begin
      group_next = group_next + GW'($signed(prods[i]));
    end
  end

  always_ff @(posedge clk) begin
    group <= group_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      last2 <= 1'b0;
    end else begin
      v2    <= ctrl.valid;
      last2 <= ctrl.valid & ctrl.last;
    end
  end

  // Saturating running sum
  logic signed [SUM_WIDTH-1:0] running_sum;
  logic                        overflow_seen;
  logic signed [AW-1:0]        total;
  logic                        add_hi;
  logic                        add_lo;
  logic signed [SUM_WIDTH-1:0] sum_new;
  logic signed [SUM_WIDTH-1:0] fin_sum;
  logic                        fin_sat;
  logic                        v3;

  assign total   = AW'(running_sum) + AW'(group);
  assign add_hi  = total > A_MAX;
  assign add_lo  = total < A_MIN;
  assign sum_new = add_hi ? A_MAX[SUM_WIDTH-1:0] :
                   add_lo ? A_MIN[SUM_WIDTH-1:0] : total[SUM_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      v3            <= 1'b0;
    end else begin
      v3 <= v2 & last2;
      if (v2) begin
        if (last2) begin
          running_sum   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          running_sum   <= sum_new;
          overflow_seen <= overflow_seen | add_hi | add_lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      fin_sum <= sum_new;
      fin_sat <= overflow_seen | add_hi | add_lo;
    end
  end

  // Metric finish: base minus sum for the inner product modes
  logic                 inner;
  logic signed [FW-1:0] base;
  logic                 base_sat;
  logic signed [FW-1:0] base_c;
  logic signed [FW-1:0] diff;
  logic                 sub_hi;
  logic                 sub_lo;

  assign inner    = (mode == METRIC_ONE_MINUS_IP) || (mode == METRIC_TWO_MINUS_IP);
  assign base     = (mode == METRIC_TWO_MINUS_IP) ? (F_ONE <<< 1) : F_ONE;
  assign base_sat = base > F_MAX;
  assign base_c   = base_sat ? F_MAX : base;
  assign diff     = base_c - FW'(fin_sum);
  assign sub_hi   = diff > F_MAX;
  assign sub_lo   = diff < F_MIN;

  always_comb begin
    if (!inner) begin
      res_dist = fin_sum;
      res_sat  = fin_sat;
    end else begin
      res_dist = sub_hi ? F_MAX[SUM_WIDTH-1:0] :
                 sub_lo ? F_MIN[SUM_WIDTH-1:0] : diff[SUM_WIDTH-1:0];
      res_sat  = fin_sat | base_sat | sub_hi | sub_lo;
    end
  end

  assign res_valid = v3;
  assign pending   = {1'b0, last2 & v2} + {1'b0, v3};

endmodule
